// File: rtl/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared constants and types for the LZW variable-width decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  localparam int TABLE_CODE_BITS = 16;
  localparam int GROUP_BYTES_MAX = 16;

  localparam logic [15:0] RESET_CODE  = 16'd256;
  localparam logic [4:0]  FIRST_WIDTH = 5'd9;
  localparam logic [16:0] FIRST_LIMIT = 17'd511;

  // request kinds
  localparam logic [1:0] KIND_FEED    = 2'd0;
  localparam logic [1:0] KIND_REQUEST = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // result status codes
  localparam logic [2:0] ST_BYTE    = 3'd0;
  localparam logic [2:0] ST_TAKEN   = 3'd1;
  localparam logic [2:0] ST_NEED    = 3'd2;
  localparam logic [2:0] ST_REFUSED = 3'd3;
  localparam logic [2:0] ST_ENDED   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_CLEAR_ENABLED = 2'd0;
  localparam logic [1:0] CFG_MAX_CODE_BITS = 2'd1;

  typedef struct packed {
    logic        en;
    logic [15:0] prefix;
    logic [7:0]  suffix;
  } dict_wr_t;

  typedef struct packed {
    logic [15:0] prefix;
    logic [7:0]  suffix;
  } dict_rd_t;

endpackage

// File: rtl/lzwd_dict.sv
// ----------------------------------------------------------------------------
// lzwd_dict
// String dictionary: prefix and suffix memories, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module lzwd_dict #(
  parameter int AW = lzwd_pkg::TABLE_CODE_BITS
) (
  input  logic              clk_i,
  input  logic              rd_en_i,
  input  logic [AW-1:0]     rd_addr_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  lzwd_pkg::dict_wr_t wr_i,
  output lzwd_pkg::dict_rd_t rd_o
);

  logic [15:0] prefix_mem [2**AW];
  logic [7:0]  suffix_mem [2**AW];
  lzwd_pkg::dict_rd_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      prefix_mem[wr_addr_i] <= wr_i.prefix;
      suffix_mem[wr_addr_i] <= wr_i.suffix;
    end
    if (rd_en_i) begin
      rd_q.prefix <= prefix_mem[rd_addr_i];
      rd_q.suffix <= suffix_mem[rd_addr_i];
    end
  end

  assign rd_o = rd_q;

endmodule

// File: rtl/lzw_variable_width_decoder.sv
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder
// Compress-style LZW decoder with 9 to max_code_bits wide codes, fed byte by
// byte and drained one output byte per request.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------
//   in      | in        | in_valid_i / in_stall_o | kind_i, in_byte_i
//   out     | out       | out_valid_o / out_stall_i | out_byte_o, status_o
//   cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Feed, end and refused requests answer in the cycle after acceptance. A request
// that pops a queued byte answers through the check and pop states (stack memory
// read). A request that decodes a code walks check, unwind for each table step
// of its string (one dictionary read per step), finish, check again and pop; the
// first code answers from check, a clear code adds a pass through check. No clearing pass after reset.
// Input stalls while a request is in work or the output register is held.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder #(
  parameter int TABLE_CODE_BITS = lzwd_pkg::TABLE_CODE_BITS,
  parameter int GROUP_BYTES_MAX = lzwd_pkg::GROUP_BYTES_MAX
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] status_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [4:0] cfg_data_i
);

  localparam int AW = TABLE_CODE_BITS;
  localparam int GW = GROUP_BYTES_MAX * 8;
  localparam logic [16:0] StackSize = 17'(2**TABLE_CODE_BITS);
  localparam logic [4:0]  TableBits = 5'(TABLE_CODE_BITS);
  localparam logic [4:0]  GroupMax  = 5'(GROUP_BYTES_MAX);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_UNWIND = 3'd2;
  localparam logic [2:0] S_FINISH = 3'd3;
  localparam logic [2:0] S_POP    = 3'd4;

  logic [2:0]    state_q, state_d;
  logic          clear_en_q;
  logic [4:0]    max_bits_q;
  logic [GW-1:0] group_q, group_d;
  logic [4:0]    fill_q, fill_d;
  logic [7:0]    offset_q, offset_d;
  logic [7:0]    usable_q, usable_d;
  logic [4:0]    width_q, width_d;
  logic [16:0]   nfc_q, nfc_d;
  logic [16:0]   limit_q, limit_d;
  logic [15:0]   prev_q, prev_d;
  logic [7:0]    lead_q, lead_d;
  logic [16:0]   cnt_q, cnt_d;
  logic          first_q, first_d;
  logic          ended_q, ended_d;
  logic [15:0]   idx_q, idx_d;
  logic [15:0]   code_q, code_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic [2:0]    status_q, status_d;

  logic [7:0]  stack_mem [2**AW];
  logic [7:0]  stk_rdata_q;
  logic        stk_we, stk_re;
  logic [AW-1:0] stk_waddr, stk_raddr;
  logic [7:0]  stk_wdata;
  logic [16:0] cnt_m1;

  logic              dict_re;
  logic [AW-1:0]     dict_raddr, dict_waddr;
  lzwd_pkg::dict_wr_t dict_wr;
  lzwd_pkg::dict_rd_t dict_rd;

  logic [4:0]  eff_max;
  logic [16:0] max_codes;
  logic [4:0]  group_size;
  logic [15:0] code_mask, take;
  logic        in_acc;

  lzwd_dict #(.AW(AW)) u_dict (
    .clk_i     (clk_i),
    .rd_en_i   (dict_re),
    .rd_addr_i (dict_raddr),
    .wr_addr_i (dict_waddr),
    .wr_i      (dict_wr),
    .rd_o      (dict_rd)
  );

  assign eff_max    = (max_bits_q < lzwd_pkg::FIRST_WIDTH) ? lzwd_pkg::FIRST_WIDTH :
                      (max_bits_q > TableBits) ? TableBits : max_bits_q;
  assign max_codes  = 17'(1) << eff_max;
  assign group_size = (width_q < GroupMax) ? width_q : GroupMax;
  assign code_mask  = 16'((17'(1) << width_q) - 17'(1));
  assign take       = group_q[15:0] & code_mask;
  assign cnt_m1     = cnt_q - 17'd1;

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign status_o    = status_q;

  // usable bits of a group of fill bytes: 8*fill - (width - 1), floored at 0
  function automatic logic [7:0] usable_of(input logic [4:0] fill, input logic [4:0] w);
    logic [7:0] bits;
    logic [7:0] wm1;
    bits = {fill, 3'b000};
    wm1  = {3'b000, w - 5'd1};
    return (bits > wm1) ? (bits - wm1) : 8'd0;
  endfunction

  always_comb begin
    logic [16:0] cnt_n;
    logic [15:0] idx_n;
    logic [16:0] nfc_n;
    logic [4:0]  w_n;
    logic [7:0]  ofs_n;

    state_d     = state_q;
    group_d     = group_q;
    fill_d      = fill_q;
    offset_d    = offset_q;
    usable_d    = usable_q;
    width_d     = width_q;
    nfc_d       = nfc_q;
    limit_d     = limit_q;
    prev_d      = prev_q;
    lead_d      = lead_q;
    cnt_d       = cnt_q;
    first_d     = first_q;
    ended_d     = ended_q;
    idx_d       = idx_q;
    code_d      = code_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    status_d    = status_q;

    stk_we     = 1'b0;
    stk_waddr  = cnt_q[AW-1:0];
    stk_wdata  = lead_q;
    stk_re     = 1'b0;
    stk_raddr  = cnt_m1[AW-1:0];
    dict_re    = 1'b0;
    dict_raddr = idx_q[AW-1:0];
    dict_waddr = nfc_q[AW-1:0];
    dict_wr    = '{en: 1'b0, prefix: prev_q, suffix: idx_q[7:0]};

    cnt_n = cnt_q;
    idx_n = idx_q;
    nfc_n = nfc_q;
    w_n   = width_q;
    ofs_n = offset_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_byte_d = 8'd0;
          status_d   = lzwd_pkg::ST_REFUSED;
          case (kind_i)
            lzwd_pkg::KIND_FEED: begin
              if (!ended_q && usable_q == 8'd0 && fill_q < group_size) begin
                for (int i = 0; i < GROUP_BYTES_MAX; i++) begin
                  if (fill_q == 5'(i)) group_d[8*i +: 8] = in_byte_i;
                end
                fill_d = fill_q + 5'd1;
                if (fill_d >= group_size) usable_d = usable_of(fill_d, width_q);
                status_d = lzwd_pkg::ST_TAKEN;
              end
              out_valid_d = 1'b1;
            end
            lzwd_pkg::KIND_END: begin
              if (!ended_q && usable_q == 8'd0 && fill_q != 5'd0) begin
                usable_d = usable_of(fill_q, width_q);
              end
              ended_d     = 1'b1;
              status_d    = lzwd_pkg::ST_TAKEN;
              out_valid_d = 1'b1;
            end
            lzwd_pkg::KIND_REQUEST: state_d = S_CHECK;
            default: out_valid_d = 1'b1;
          endcase
        end
      end

      S_CHECK: begin
        if (cnt_q != 17'd0) begin
          stk_re  = 1'b1;
          cnt_d   = cnt_q - 17'd1;
          state_d = S_POP;
        end else if (usable_q == 8'd0) begin
          out_valid_d = 1'b1;
          out_byte_d  = 8'd0;
          status_d    = ended_q ? lzwd_pkg::ST_ENDED : lzwd_pkg::ST_NEED;
          state_d     = S_IDLE;
        end else begin
          // cut one code off the group
          group_d  = group_q >> width_q;
          ofs_n    = offset_q + {3'b000, width_q};
          offset_d = ofs_n;
          if (ofs_n >= usable_q) begin
            fill_d   = 5'd0;
            offset_d = 8'd0;
            usable_d = 8'd0;
          end
          code_d = take;
          if (first_q) begin
            first_d     = 1'b0;
            nfc_d       = clear_en_q ? 17'd257 : 17'd256;
            limit_d     = lzwd_pkg::FIRST_LIMIT;
            prev_d      = take;
            lead_d      = take[7:0];
            out_valid_d = 1'b1;
            out_byte_d  = take[7:0];
            status_d    = lzwd_pkg::ST_BYTE;
            state_d     = S_IDLE;
          end else if (take == lzwd_pkg::RESET_CODE && clear_en_q) begin
            nfc_d    = 17'd256;
            width_d  = lzwd_pkg::FIRST_WIDTH;
            limit_d  = lzwd_pkg::FIRST_LIMIT;
            fill_d   = 5'd0;
            offset_d = 8'd0;
            usable_d = 8'd0;
          end else begin
            if ({1'b0, take} >= nfc_q) begin
              // code not yet in the table: previous string plus its lead byte
              if (cnt_q < StackSize) begin
                stk_we = 1'b1;
                cnt_n  = cnt_q + 17'd1;
              end
              idx_n = prev_q;
            end else begin
              idx_n = take;
            end
            cnt_d      = cnt_n;
            idx_d      = idx_n;
            dict_raddr = idx_n[AW-1:0];
            if (idx_n >= lzwd_pkg::RESET_CODE && cnt_n < StackSize) begin
              dict_re = 1'b1;
              state_d = S_UNWIND;
            end else begin
              state_d = S_FINISH;
            end
          end
        end
      end

      S_UNWIND: begin
        stk_we     = 1'b1;
        stk_wdata  = dict_rd.suffix;
        cnt_n      = cnt_q + 17'd1;
        cnt_d      = cnt_n;
        idx_d      = dict_rd.prefix;
        dict_raddr = dict_rd.prefix[AW-1:0];
        if (dict_rd.prefix >= lzwd_pkg::RESET_CODE && cnt_n < StackSize) begin
          dict_re = 1'b1;
        end else begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        stk_wdata = idx_q[7:0];
        if (cnt_q < StackSize) begin
          stk_we = 1'b1;
          cnt_d  = cnt_q + 17'd1;
        end
        if (nfc_q < max_codes) begin
          dict_wr.en = 1'b1;
          nfc_n      = nfc_q + 17'd1;
        end
        nfc_d  = nfc_n;
        prev_d = code_q;
        lead_d = idx_q[7:0];
        if (nfc_n > limit_q) begin
          w_n = width_q + 5'd1;
          if (w_n >= eff_max) begin
            width_d = eff_max;
            limit_d = max_codes;
          end else begin
            width_d = w_n;
            limit_d = (17'(1) << w_n) - 17'd1;
          end
          fill_d   = 5'd0;
          offset_d = 8'd0;
          usable_d = 8'd0;
        end
        state_d = S_CHECK;
      end

      S_POP: begin
        out_valid_d = 1'b1;
        out_byte_d  = stk_rdata_q;
        status_d    = lzwd_pkg::ST_BYTE;
        state_d     = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) stack_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rdata_q <= stack_mem[stk_raddr];
  end

  always_ff @(posedge clk_i) begin
    group_q    <= group_d;
    idx_q      <= idx_d;
    code_q     <= code_d;
    out_byte_q <= out_byte_d;
    status_q   <= status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clear_en_q  <= 1'b1;
      max_bits_q  <= 5'd16;
      fill_q      <= 5'd0;
      offset_q    <= 8'd0;
      usable_q    <= 8'd0;
      width_q     <= lzwd_pkg::FIRST_WIDTH;
      nfc_q       <= 17'd257;
      limit_q     <= lzwd_pkg::FIRST_LIMIT;
      prev_q      <= 16'd0;
      lead_q      <= 8'd0;
      cnt_q       <= 17'd0;
      first_q     <= 1'b1;
      ended_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      offset_q    <= offset_d;
      usable_q    <= usable_d;
      width_q     <= width_d;
      nfc_q       <= nfc_d;
      limit_q     <= limit_d;
      prev_q      <= prev_d;
      lead_q      <= lead_d;
      cnt_q       <= cnt_d;
      first_q     <= first_d;
      ended_q     <= ended_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          lzwd_pkg::CFG_CLEAR_ENABLED: clear_en_q <= cfg_data_i[0];
          lzwd_pkg::CFG_MAX_CODE_BITS: max_bits_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= StackSize) else $error("string stack count past its depth");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("input taken while busy");

  a_offset_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (usable_q != 8'd0) |-> (offset_q < usable_q))
    else $error("bit offset past the usable bits");

  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (width_q >= lzwd_pkg::FIRST_WIDTH) && (width_q <= TableBits))
    else $error("code width out of range");

  a_pop_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |=> (out_valid_q && status_q == lzwd_pkg::ST_BYTE))
    else $error("popped byte not delivered");

endmodule

// File: tb/sv/lzw_variable_width_decoder_tb.sv
// ----------------------------------------------------------------------------
// lzw_variable_width_decoder_tb
// Self-checking bench for the LZW decoder. A code-level stream builder keeps
// every code legal for the decoder's table, packs the codes into groups,
// and queues feed, request, end, bad-kind and config requests. A clocked
// driver and monitor run the handshakes. A predictor of the decoder gives the
// expected byte and status for each request.
// ----------------------------------------------------------------------------
module lzw_variable_width_decoder_tb;

  localparam logic [1:0] KIND_BAD = 2'd3;
  localparam int IDLE_PCT = 14;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TBL = 65536;

  typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} op_e;

  typedef struct {
    op_e        op;
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] idx;
    logic [4:0] val;
  } req_t;

  typedef struct {
    logic [7:0] out_byte;
    logic [2:0] status;
  } result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] kind_i = lzwd_pkg::KIND_FEED;
  logic [7:0] in_byte_i = 8'd0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [2:0] status_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = lzwd_pkg::CFG_CLEAR_ENABLED;
  logic [4:0] cfg_data_i = 5'd0;

  lzw_variable_width_decoder dut (.*);

  always #6 clk_i = ~clk_i;

  req_t    pending_req[$];
  result_t expected_result[$];
  int      n_items = 0;
  int      fail_cnt = 0;
  int      results_seen = 0;
  int      cycle_cnt = 0;
  int      idle_cycles = 0;
  logic    in_acc = 1'b0;
  logic    cfg_acc = 1'b0;
  logic    run = 1'b0;

  // --------------------------------------------------------------------------
  // decoder predictor
  // --------------------------------------------------------------------------
  bit [15:0] dec_prefix[TBL];
  bit [7:0]  dec_suffix[TBL];
  bit [7:0]  dec_stack[TBL];
  bit [7:0]  dec_group[lzwd_pkg::GROUP_BYTES_MAX];
  int dec_fill = 0, dec_off = 0, dec_usable = 0, dec_width = 9;
  int dec_next = 257, dec_limit = 511, dec_prev = 0, dec_lead = 0, dec_sp = 0;
  bit dec_first = 1, dec_ended = 0;
  int reg_clear = 1, reg_maxbits = 16;

  function automatic int sat_bits(int m);
    if (m < int'(lzwd_pkg::FIRST_WIDTH)) return int'(lzwd_pkg::FIRST_WIDTH);
    if (m > lzwd_pkg::TABLE_CODE_BITS) return lzwd_pkg::TABLE_CODE_BITS;
    return m;
  endfunction

  function automatic int group_len();
    return dec_width < lzwd_pkg::GROUP_BYTES_MAX ? dec_width : lzwd_pkg::GROUP_BYTES_MAX;
  endfunction

  function automatic void drop_group();
    dec_fill = 0;
    dec_off = 0;
    dec_usable = 0;
  endfunction

  function automatic void load_group();
    int bits;
    bits = dec_fill * 8 - (dec_width - 1);
    dec_usable = bits > 0 ? bits : 0;
  endfunction

  function automatic int group_at(int i);
    return i < lzwd_pkg::GROUP_BYTES_MAX ? int'(dec_group[i]) : 0;
  endfunction

  function automatic int take_code();
    int b, v, code;
    b = dec_off >> 3;
    v = group_at(b) | (group_at(b + 1) << 8) | (group_at(b + 2) << 16);
    code = (v >> (dec_off & 'h7)) & ((1 << dec_width) - 1);
    dec_off += dec_width;
    if (dec_off >= dec_usable) drop_group();
    return code;
  endfunction

  function automatic void stack_push(int v);
    if (dec_sp < TBL) begin
      dec_stack[dec_sp] = v[7:0];
      dec_sp++;
    end
  endfunction

  function automatic void unwind_code(int code);
    int idx, top, mb;
    top = 1 << sat_bits(reg_maxbits);
    if (code >= dec_next) begin
      stack_push(dec_lead);
      idx = dec_prev;
    end else begin
      idx = code;
    end
    while (idx >= int'(lzwd_pkg::RESET_CODE) && dec_sp < TBL) begin
      stack_push(int'(dec_suffix[idx & (TBL - 1)]));
      idx = int'(dec_prefix[idx & (TBL - 1)]);
    end
    stack_push(idx & 'hFF);
    if (dec_next < top) begin
      dec_prefix[dec_next] = dec_prev[15:0];
      dec_suffix[dec_next] = idx[7:0];
      dec_next++;
    end
    dec_prev = code & 'hFFFF;
    dec_lead = idx & 'hFF;
    if (dec_next > dec_limit) begin
      mb = sat_bits(reg_maxbits);
      dec_width++;
      if (dec_width >= mb) begin
        dec_width = mb;
        dec_limit = top;
      end else begin
        dec_limit = (1 << dec_width) - 1;
      end
      drop_group();
    end
  endfunction

  function automatic result_t decode_request(logic [1:0] kind, logic [7:0] data);
    result_t r;
    int code;
    r.out_byte = 8'd0;
    r.status = lzwd_pkg::ST_REFUSED;
    if (kind == lzwd_pkg::KIND_FEED) begin
      if (!dec_ended && dec_usable == 0 && dec_fill < group_len()) begin
        dec_group[dec_fill] = data;
        dec_fill++;
        if (dec_fill >= group_len()) load_group();
        r.status = lzwd_pkg::ST_TAKEN;
      end
    end else if (kind == lzwd_pkg::KIND_END) begin
      if (!dec_ended && dec_usable == 0 && dec_fill > 0) load_group();
      dec_ended = 1;
      r.status = lzwd_pkg::ST_TAKEN;
    end else if (kind == lzwd_pkg::KIND_REQUEST) begin
      forever begin
        if (dec_sp > 0) begin
          dec_sp--;
          r.out_byte = dec_stack[dec_sp];
          r.status = lzwd_pkg::ST_BYTE;
          break;
        end
        if (dec_usable == 0) begin
          r.status = dec_ended ? lzwd_pkg::ST_ENDED : lzwd_pkg::ST_NEED;
          break;
        end
        code = take_code();
        if (dec_first) begin
          dec_first = 0;
          dec_next = reg_clear ? int'(lzwd_pkg::RESET_CODE) + 1 : int'(lzwd_pkg::RESET_CODE);
          dec_limit = int'(lzwd_pkg::FIRST_LIMIT);
          dec_prev = code & 'hFFFF;
          dec_lead = code & 'hFF;
          r.out_byte = dec_lead[7:0];
          r.status = lzwd_pkg::ST_BYTE;
          break;
        end
        if (code == int'(lzwd_pkg::RESET_CODE) && reg_clear) begin
          dec_next = int'(lzwd_pkg::RESET_CODE);
          dec_width = int'(lzwd_pkg::FIRST_WIDTH);
          dec_limit = int'(lzwd_pkg::FIRST_LIMIT);
          drop_group();
          continue;
        end
        unwind_code(code);
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stream builder: mirrors the decoder's table so every code stays legal
  // --------------------------------------------------------------------------
  bit         enc_written[TBL];
  int         enc_len[TBL];
  int         enc_next = 257, enc_width = 9, enc_limit = 511, enc_prev = 0;
  bit         enc_first = 1;
  int         enc_clear = 1, enc_maxbits = 16;
  logic [127:0] grp_bits = '0;
  int         grp_pos = 0, grp_w = 9, pend_out = 0;

  task automatic push_item(logic [1:0] kind, logic [7:0] data);
    pending_req.push_back('{OP_ITEM, kind, data, 2'd0, 5'd0});
    n_items++;
  endtask

  task automatic push_cfg(logic [1:0] idx, logic [4:0] val);
    pending_req.push_back('{OP_CFG, lzwd_pkg::KIND_FEED, 8'd0, idx, val});
    if (idx == lzwd_pkg::CFG_CLEAR_ENABLED) enc_clear = int'(val[0]);
    else enc_maxbits = int'(val);
  endtask

  task automatic flush_group();
    logic [7:0] b;
    if (grp_pos == 0) return;
    for (int i = 0; i < grp_w; i++) begin
      b = grp_bits[8*i +: 8];
      for (int j = 0; j < 8; j++)
        if (8 * i + j >= grp_pos) b[j] = 1'($urandom_range(1));
      push_item(lzwd_pkg::KIND_FEED, b);
    end
    // group is loaded and unused: an extra byte must bounce
    if (n_items < 40 || $urandom_range(99) < 8) push_item(lzwd_pkg::KIND_FEED, 8'($urandom));
    if ($urandom_range(99) < 3) push_item(KIND_BAD, 8'($urandom));
    for (int i = 0; i <= pend_out; i++) push_item(lzwd_pkg::KIND_REQUEST, 8'($urandom));
    if ($urandom_range(99) < 10) push_item(lzwd_pkg::KIND_REQUEST, 8'($urandom));
    pend_out = 0;
    grp_bits = '0;
    grp_pos = 0;
  endtask

  task automatic put_code(int c);
    int top, mb;
    if (grp_pos == 0) grp_w = enc_width;
    grp_bits |= 128'(c) << grp_pos;
    grp_pos += enc_width;
    if (enc_first) begin
      enc_first = 0;
      enc_next = enc_clear ? 257 : 256;
      enc_limit = 511;
      enc_prev = c;
      pend_out++;
    end else if (c == int'(lzwd_pkg::RESET_CODE) && enc_clear) begin
      enc_next = 256;
      enc_width = 9;
      enc_limit = 511;
      flush_group();
      return;
    end else begin
      mb = sat_bits(enc_maxbits);
      top = 1 << mb;
      pend_out += (c >= enc_next) ? enc_len[enc_prev] + 1 : enc_len[c];
      if (enc_next < top) begin
        enc_written[enc_next] = 1;
        enc_len[enc_next] = enc_len[enc_prev] + 1;
        enc_next++;
      end
      enc_prev = c;
      if (enc_next > enc_limit) begin
        enc_width++;
        if (enc_width >= mb) begin
          enc_width = mb;
          enc_limit = top;
        end else begin
          enc_limit = (1 << enc_width) - 1;
        end
        flush_group();
        return;
      end
    end
    if (grp_pos >= 8 * grp_w) flush_group();
  endtask

  function automatic bit usable_entry(int c);
    if (c >= (1 << enc_width)) return 0;
    if (c == int'(lzwd_pkg::RESET_CODE) && enc_clear) return 0;
    return c < 256 || (enc_written[c] && enc_len[c] <= 6);
  endfunction

  // returns -1 to ask for a clear code
  function automatic int pick_code();
    int r, c;
    if (enc_first) return $urandom_range(255);
    r = $urandom_range(99);
    if (r < 12) begin
      c = enc_next;
      if (c < (1 << sat_bits(enc_maxbits)) && c < (1 << enc_width) &&
          !(c == int'(lzwd_pkg::RESET_CODE) && enc_clear) && enc_len[enc_prev] <= 6)
        return c;
    end else if (r < 45 && enc_next > 256) begin
      for (int t = 0; t < 4; t++) begin
        c = $urandom_range(256, enc_next - 1);
        if (usable_entry(c)) return c;
      end
    end else if (r < 47 && enc_clear) begin
      return -1;
    end
    if (r < 52) return (r & 1) ? 255 : 0;
    return $urandom_range(255);
  endfunction

  task automatic build_stream();
    int phase, c, k;
    for (int i = 0; i < TBL; i++) enc_len[i] = 1;
    // directed: bad kind, request on empty, then every code flavor
    push_item(KIND_BAD, 8'hFF);
    push_item(lzwd_pkg::KIND_REQUEST, 8'h00);
    push_item(KIND_BAD, 8'h00);
    put_code('h41);
    put_code(255);
    put_code(0);
    put_code(enc_next);
    put_code(257);
    put_code(0);
    put_code(int'(lzwd_pkg::RESET_CODE));
    put_code('h80);
    put_code(enc_next);
    phase = 0;
    while (n_items < 1700) begin
      if (grp_pos == 0) begin
        if (phase == 0 && n_items >= 60) begin
          push_cfg(lzwd_pkg::CFG_MAX_CODE_BITS, 5'd9);
          phase = 1;
        end else if (phase == 1 && ((enc_next >= 512 && $urandom_range(19) == 0) ||
                                    n_items >= 1100)) begin
          push_cfg(lzwd_pkg::CFG_CLEAR_ENABLED, 5'd0);
          push_cfg(lzwd_pkg::CFG_MAX_CODE_BITS, 5'd10);
          phase = 2;
        end else if (phase == 2 && n_items >= 1300) begin
          pending_req.push_back('{OP_DRAIN, lzwd_pkg::KIND_FEED, 8'd0, 2'd0, 5'd0});
          push_cfg(lzwd_pkg::CFG_MAX_CODE_BITS, 5'd31);
          push_cfg(lzwd_pkg::CFG_CLEAR_ENABLED, 5'd1);
          phase = 3;
        end else if (phase == 3 && n_items >= 1500) begin
          push_cfg(lzwd_pkg::CFG_MAX_CODE_BITS, 5'd16);
          phase = 4;
        end
      end
      c = pick_code();
      if (c < 0) begin
        // a literal ahead of the clear keeps the next entry's prefix simple
        put_code($urandom_range(255));
        put_code(int'(lzwd_pkg::RESET_CODE));
      end else begin
        put_code(c);
      end
    end
    // tail: partial group, end of input, then drain and poke the ended stream
    k = $urandom_range(1, 7);
    for (int i = 0; i < k; i++) begin
      do c = pick_code(); while (c < 0);
      put_code(c);
    end
    for (int i = 0; i < (grp_pos + 7) / 8; i++)
      push_item(lzwd_pkg::KIND_FEED, grp_bits[8*i +: 8]);
    push_item(lzwd_pkg::KIND_END, 8'($urandom));
    for (int i = 0; i <= pend_out + 2; i++) push_item(lzwd_pkg::KIND_REQUEST, 8'($urandom));
    push_item(lzwd_pkg::KIND_FEED, 8'($urandom));
    push_item(lzwd_pkg::KIND_END, 8'($urandom));
    push_item(KIND_BAD, 8'($urandom));
    push_item(lzwd_pkg::KIND_REQUEST, 8'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // driver, receiver and monitor
  // --------------------------------------------------------------------------
  function automatic bit quiet_window();
    return cycle_cnt >= 4000 && cycle_cnt < 6000;
  endfunction

  always @(negedge clk_i) begin
    bit   nv, ncv;
    req_t r;
    if (run) begin
      nv = in_valid_i;
      ncv = cfg_valid_i;
      if (in_valid_i && in_acc) nv = 1'b0;
      if (cfg_valid_i && cfg_acc) ncv = 1'b0;
      if (!nv && !ncv && pending_req.size() > 0) begin
        r = pending_req[0];
        case (r.op)
          OP_ITEM: begin
            if (quiet_window() || $urandom_range(99) >= IDLE_PCT) begin
              nv = 1'b1;
              kind_i <= r.kind;
              in_byte_i <= r.data;
              void'(pending_req.pop_front());
            end
          end
          OP_CFG: begin
            // write only once the decoder has answered everything
            if (expected_result.size() == 0) begin
              ncv = 1'b1;
              cfg_index_i <= r.idx;
              cfg_data_i <= r.val;
              void'(pending_req.pop_front());
            end
          end
          default: begin
            if (expected_result.size() == 0) void'(pending_req.pop_front());
          end
        endcase
      end
      in_valid_i <= nv;
      cfg_valid_i <= ncv;
    end
  end

  int rx_hold = 0;
  bit rx_hold_done = 0;

  always @(negedge clk_i) begin
    if (!rx_hold_done && results_seen >= 400) begin
      rx_hold_done = 1;
      rx_hold = 300;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !quiet_window() && $urandom_range(99) < IDLE_PCT;
    end
  end

  always @(posedge clk_i) begin
    result_t want, got;
    bit      moved;
    moved = 0;
    if (rst_ni) begin
      cycle_cnt++;
      if (out_valid_o && !out_stall_i) begin
        moved = 1;
        results_seen++;
        got = '{out_byte_o, status_o};
        if (expected_result.size() == 0) begin
          $error("result with nothing expected: out_byte %0h status %0d",
                 got.out_byte, got.status);
          fail_cnt++;
        end else begin
          want = expected_result.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_cnt++;
          end
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1;
        expected_result.push_back(decode_request(kind_i, in_byte_i));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1;
        if (cfg_index_i == lzwd_pkg::CFG_CLEAR_ENABLED) reg_clear = int'(cfg_data_i[0]);
        else if (cfg_index_i == lzwd_pkg::CFG_MAX_CODE_BITS) reg_maxbits = int'(cfg_data_i);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** lzw_variable_width_decoder: FAILED **");
        $finish;
      end
    end
    in_acc <= in_valid_i && !in_stall_o;
    cfg_acc <= cfg_valid_i && cfg_ready_o;
  end

  initial begin
    build_stream();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    run = 1'b1;
    wait (pending_req.size() == 0 && !in_valid_i && !cfg_valid_i);
    wait (expected_result.size() == 0);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && expected_result.size() == 0) begin
      $display("** lzw_variable_width_decoder: PASSED **");
    end else begin
      $display("** lzw_variable_width_decoder: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/lzwd_pkg.sv
rtl/lzwd_dict.sv
rtl/lzw_variable_width_decoder.sv
tb/sv/lzw_variable_width_decoder_tb.sv
